### rtl/core/efla_pkg.sv
// Shared constants, codes and helpers for the explicit free list allocator.
// No dependencies; imported by the top level.
package efla_pkg;

  localparam int HEAP_WORDS_DEF = 16384;
  localparam int WORD_BYTES     = 8;
  localparam int DATA_W         = 32;
  localparam int ADDR_W         = 17;
  localparam int REQ_W          = 18;
  localparam int CHUNK_W        = 17;
  localparam int LIMIT_W        = 18;
  localparam int STAT_W         = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 18;

  localparam logic [31:0] DBL        = 32'(2 * WORD_BYTES);
  localparam logic [31:0] MIN_BLOCK  = 32'(4 * WORD_BYTES);
  localparam logic [31:0] INIT_CHUNK = 32'(1 << 12);
  localparam logic [31:0] ALLOC_BIT  = 32'h1;
  localparam logic [31:0] FIRST_BP   = 32'(4 * WORD_BYTES);
  localparam logic [31:0] INIT_END   = 32'(4 * WORD_BYTES) + INIT_CHUNK;

  localparam logic [31:0] PRO_HDR_IDX  = 32'd1;
  localparam logic [31:0] PRO_FTR_IDX  = 32'd2;
  localparam logic [31:0] INIT_HDR_IDX = 32'd3;
  localparam logic [31:0] INIT_FTR_IDX = (INIT_END - DBL) / WORD_BYTES;
  localparam logic [31:0] INIT_EPI_IDX = (INIT_END - 32'(WORD_BYTES)) / WORD_BYTES;

  localparam logic [17:0] CHUNK_RST = 18'd4096;
  localparam logic [17:0] LIMIT_RST = 18'd131072;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_ZERO     = 2'd2;

  localparam logic [1:0] CFG_CHUNK = 2'd0;
  localparam logic [1:0] CFG_LIMIT = 2'd1;

  // Round up to a multiple of the double word.
  function automatic logic [31:0] round_dbl(input logic [31:0] x);
    return (x + DBL - 32'd1) & ~(DBL - 32'd1);
  endfunction

  // Contents of a store word right after reset.
  function automatic logic [31:0] init_word(input logic [31:0] idx, input logic fits);
    logic [31:0] w;
    w = '0;
    if (idx == PRO_HDR_IDX || idx == PRO_FTR_IDX) w = DBL | ALLOC_BIT;
    else if (idx == INIT_HDR_IDX) w = fits ? INIT_CHUNK : ALLOC_BIT;
    else if (fits && idx == INIT_FTR_IDX) w = INIT_CHUNK;
    else if (fits && idx == INIT_EPI_IDX) w = ALLOC_BIT;
    return w;
  endfunction

endpackage

### rtl/core/efla_ram.sv
// Generic single port synchronous RAM with registered read data.
// No dependencies.
module efla_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/core/explicit_free_list_allocator.sv
// Top level of the explicit free list heap allocator: request sequencer and heap store.
// Depends on efla_pkg and efla_ram.
//
// Usage:
//  - Request channel (in_valid/in_ready): mode selects allocate or free; req_size is the
//    payload size of an allocate, block_addr the payload address of a block to free.
//  - Result channel (out_valid/out_ready): exactly one result per request, result_addr and
//    status (ok, out of heap space, zero size). Results come out in request order.
//  - Config channel (cfg_valid/cfg_ready, always ready): index 0 sets chunk_bytes, index 1
//    sets heap_limit_bytes; other indexes are dropped. Write only while the block is idle.
//  - Reset clears the heap store with one word per cycle and lays down prologue, one free
//    chunk (when the store holds it) and epilogue; in_ready stays low during that pass.
//  - Block headers, footers and links live in a single port RAM, so every access is a
//    state of its own, and a read gives the address first, then uses the registered data.
//  - Work per request: a zero size allocate goes straight to the result; an allocate walks
//    the free list first fit, grows the heap if no block fits, then unlinks the block and
//    splits off a large enough tail, inserted by an ordered walk of the list; a free walks
//    block headers from the heap base, then merges with free neighbours and inserts.
//  - One request is in work at a time. A finished result sits in the output register;
//    the next request is accepted while it waits. If the receiver stalls, the sequencer
//    holds its next result until the output register empties.
module explicit_free_list_allocator #(
  parameter int HEAP_WORDS = efla_pkg::HEAP_WORDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             mode,
  input  logic [efla_pkg::REQ_W-1:0]       req_size,
  input  logic [efla_pkg::ADDR_W-1:0]      block_addr,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [efla_pkg::ADDR_W-1:0]      result_addr,
  output logic [efla_pkg::STAT_W-1:0]      status,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [efla_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [efla_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import efla_pkg::*;

  localparam int IDX_W = $clog2(HEAP_WORDS);
  localparam int CNT_W = $clog2(HEAP_WORDS + 1);
  localparam logic [31:0] STORE_WORDS = 32'(HEAP_WORDS);
  localparam logic [31:0] STORE_BYTES = 32'(HEAP_WORDS * WORD_BYTES);
  localparam logic FITS = (STORE_BYTES >= INIT_END);
  localparam logic [CNT_W-1:0] WALK_MAX = CNT_W'(HEAP_WORDS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HEAP_WORDS - 1);

  typedef enum logic [5:0] {
    S_CLR, S_IDLE, S_DONE,
    S_FF_CHK, S_FF_SZ, S_FF_NX,
    S_GR_START, S_GR_EPI,
    S_TK_START, S_TK_SZ, S_TK_SPLIT, S_TK_REM, S_TK_INS,
    S_ST_W1, S_ST_W2,
    S_RM_R1, S_RM_R2, S_RM_R3, S_RM_W2,
    S_IN_CHK, S_IN_NX, S_IN_W1, S_IN_W2, S_IN_W3, S_IN_W4,
    S_MG_START, S_MG_SZ, S_MG_NU, S_MG_PU,
    S_MG_B_RD, S_MG_B_SZ, S_MG_B_INS,
    S_MG_C_RD, S_MG_C_SZ,
    S_MG_D_RD1, S_MG_D_RD2, S_MG_D_SZ,
    S_MG_END,
    S_FR_CHK, S_FR_HD, S_FR_MG
  } state_t;

  state_t state, st_ret, rm_ret, ins_ret;

  logic [IDX_W-1:0]   clr_idx;
  logic [CHUNK_W-1:0] chunk;
  logic [LIMIT_W-1:0] limit;
  logic [31:0]        free_head;
  logic [LIMIT_W-1:0] heap_top;

  logic [31:0] asize, addr_q, res, wk, tbp, csize, gsize;
  logic [1:0]  stat;
  logic [CNT_W-1:0] n;
  logic [31:0] st_bp, st_size;
  logic        st_a;
  logic [31:0] rm_bp, rm_nx, rm_pv;
  logic [31:0] in_bp, in_cur, in_pv;
  logic [31:0] mbp, msize, nb, pb;
  logic        mg_nu, mg_grow;
  logic        rd_ok;

  // Memory port
  logic [31:0]      acc_addr, acc_wdata;
  logic             acc_we, acc_in;
  logic             mem_we;
  logic [IDX_W-1:0] mem_addr;
  logic [31:0]      mem_wdata, mem_rdata, rdv;

  // Growth check
  logic [31:0] top32, gr_bytes, gr_size, gr_lim;
  logic        gr_fail;
  logic [31:0] rsz, tk_diff;

  assign top32   = {{(32-LIMIT_W){1'b0}}, heap_top};
  assign rdv     = rd_ok ? mem_rdata : '0;
  assign rsz     = rdv & ~ALLOC_BIT;
  assign tk_diff = csize - asize;

  always_comb begin
    gr_bytes = (asize > {15'd0, chunk}) ? asize : {15'd0, chunk};
    gr_size  = round_dbl(gr_bytes & ~32'(WORD_BYTES - 1));
    gr_lim   = ({14'd0, limit} < STORE_BYTES) ? {14'd0, limit} : STORE_BYTES;
    gr_fail  = (gr_size == '0) || (gr_size > gr_lim) || (top32 > gr_lim - gr_size);
  end

  // Address, write enable and data of the single store access in each state.
  always_comb begin
    acc_addr  = '0;
    acc_we    = 1'b0;
    acc_wdata = '0;
    case (state)
      S_FF_CHK:   acc_addr = wk - 32'(WORD_BYTES);
      S_FF_SZ:    acc_addr = wk + 32'(WORD_BYTES);
      S_TK_START: acc_addr = tbp - 32'(WORD_BYTES);
      S_ST_W1: begin
        acc_addr  = st_bp - 32'(WORD_BYTES);
        acc_we    = 1'b1;
        acc_wdata = st_size | {31'd0, st_a};
      end
      S_ST_W2: begin
        acc_addr  = st_bp + st_size - DBL;
        acc_we    = 1'b1;
        acc_wdata = st_size | {31'd0, st_a};
      end
      S_GR_EPI: begin
        acc_addr  = mbp + gsize - 32'(WORD_BYTES);
        acc_we    = 1'b1;
        acc_wdata = ALLOC_BIT;
      end
      S_RM_R1: acc_addr = rm_bp + 32'(WORD_BYTES);
      S_RM_R2: acc_addr = rm_bp;
      S_RM_R3: begin
        acc_addr  = rdv + 32'(WORD_BYTES);
        acc_we    = (rdv != '0);
        acc_wdata = rm_nx;
      end
      S_RM_W2: begin
        acc_addr  = rm_nx;
        acc_we    = (rm_nx != '0);
        acc_wdata = rm_pv;
      end
      S_IN_CHK: acc_addr = in_cur + 32'(WORD_BYTES);
      S_IN_W1: begin
        acc_addr  = in_bp;
        acc_we    = 1'b1;
        acc_wdata = in_pv;
      end
      S_IN_W2: begin
        acc_addr  = in_bp + 32'(WORD_BYTES);
        acc_we    = 1'b1;
        acc_wdata = in_cur;
      end
      S_IN_W3: begin
        acc_addr  = in_pv + 32'(WORD_BYTES);
        acc_we    = (in_pv != '0);
        acc_wdata = in_bp;
      end
      S_IN_W4: begin
        acc_addr  = in_cur;
        acc_we    = (in_cur != '0);
        acc_wdata = in_bp;
      end
      S_MG_START: acc_addr = mbp - 32'(WORD_BYTES);
      S_MG_SZ:    acc_addr = mbp + rsz - 32'(WORD_BYTES);
      S_MG_NU:    acc_addr = mbp - DBL;
      S_MG_B_RD:  acc_addr = nb - 32'(WORD_BYTES);
      S_MG_C_RD:  acc_addr = pb - 32'(WORD_BYTES);
      S_MG_D_RD1: acc_addr = pb - 32'(WORD_BYTES);
      S_MG_D_RD2: acc_addr = nb - 32'(WORD_BYTES);
      S_FR_CHK:   acc_addr = wk - 32'(WORD_BYTES);
      default: ;
    endcase
  end

  // Byte addresses outside the store read as zero and drop writes.
  assign acc_in    = (acc_addr >> 3) < STORE_WORDS;
  assign mem_we    = (state == S_CLR) ? 1'b1 : (acc_we && acc_in);
  assign mem_addr  = (state == S_CLR) ? clr_idx : acc_addr[IDX_W+2:3];
  assign mem_wdata = (state == S_CLR) ? init_word({{(32-IDX_W){1'b0}}, clr_idx}, FITS)
                                      : acc_wdata;

  efla_ram #(
    .WIDTH(DATA_W),
    .DEPTH(HEAP_WORDS)
  ) u_heap (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    rd_ok <= acc_in;
    if (rst) begin
      state     <= S_CLR;
      clr_idx   <= '0;
      chunk     <= CHUNK_RST[CHUNK_W-1:0];
      limit     <= LIMIT_RST;
      free_head <= FITS ? FIRST_BP : '0;
      heap_top  <= FITS ? INIT_END[LIMIT_W-1:0] : FIRST_BP[LIMIT_W-1:0];
      out_valid <= 1'b0;
    end else begin
      // Config writes land in any state; unknown indexes are dropped.
      if (cfg_valid) begin
        case (cfg_index)
          CFG_CHUNK: chunk <= cfg_data[CHUNK_W-1:0];
          CFG_LIMIT: limit <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      // Drop the result once taken, unless the next one loads this cycle.
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;

      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_IDX) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            n    <= '0;
            res  <= '0;
            stat <= ST_OK;
            if (mode == MODE_FREE) begin
              addr_q <= {15'd0, block_addr};
              wk     <= FIRST_BP;
              state  <= S_FR_CHK;
            end else if (req_size == '0) begin
              stat  <= ST_ZERO;
              state <= S_DONE;
            end else begin
              asize <= ({14'd0, req_size} <= DBL) ? MIN_BLOCK
                                                  : round_dbl({14'd0, req_size} + DBL);
              wk    <= free_head;
              state <= S_FF_CHK;
            end
          end
        end
        S_DONE: begin
          // Hold the result until the output register is free.
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            result_addr <= res[ADDR_W-1:0];
            status      <= stat;
            state       <= S_IDLE;
          end
        end

        // First fit walk over the free list
        S_FF_CHK: state <= (wk != '0 && n < WALK_MAX) ? S_FF_SZ : S_GR_START;
        S_FF_SZ: begin
          if (asize <= rsz) begin
            tbp   <= wk;
            res   <= wk;
            state <= S_TK_START;
          end else begin
            state <= S_FF_NX;
          end
        end
        S_FF_NX: begin
          wk    <= rdv;
          n     <= n + 1'b1;
          state <= S_FF_CHK;
        end

        // Grow the heap by max(request, chunk)
        S_GR_START: begin
          if (gr_fail) begin
            stat  <= ST_NO_SPACE;
            state <= S_DONE;
          end else begin
            heap_top <= heap_top + gr_size[LIMIT_W-1:0];
            gsize    <= gr_size;
            mbp      <= top32;
            mg_grow  <= 1'b1;
            st_bp    <= top32;
            st_size  <= gr_size;
            st_a     <= 1'b0;
            st_ret   <= S_GR_EPI;
            state    <= S_ST_W1;
          end
        end
        S_GR_EPI: state <= S_MG_START;

        // Take a free block, split off the tail when large enough
        S_TK_START: state <= S_TK_SZ;
        S_TK_SZ: begin
          csize  <= rsz;
          rm_bp  <= tbp;
          rm_ret <= S_TK_SPLIT;
          state  <= S_RM_R1;
        end
        S_TK_SPLIT: begin
          st_bp <= tbp;
          st_a  <= 1'b1;
          if (tk_diff >= MIN_BLOCK) begin
            st_size <= asize;
            st_ret  <= S_TK_REM;
          end else begin
            st_size <= csize;
            st_ret  <= S_DONE;
          end
          state <= S_ST_W1;
        end
        S_TK_REM: begin
          st_bp   <= tbp + asize;
          st_size <= tk_diff;
          st_a    <= 1'b0;
          st_ret  <= S_TK_INS;
          state   <= S_ST_W1;
        end
        S_TK_INS: begin
          in_bp   <= tbp + asize;
          in_cur  <= free_head;
          in_pv   <= '0;
          n       <= '0;
          ins_ret <= S_DONE;
          state   <= S_IN_CHK;
        end

        // Header and footer write
        S_ST_W1: state <= S_ST_W2;
        S_ST_W2: state <= st_ret;

        // Unlink rm_bp
        S_RM_R1: state <= S_RM_R2;
        S_RM_R2: begin
          rm_nx <= rdv;
          state <= S_RM_R3;
        end
        S_RM_R3: begin
          rm_pv <= rdv;
          if (rdv == '0) free_head <= rm_nx;
          state <= S_RM_W2;
        end
        S_RM_W2: state <= rm_ret;

        // Ordered insert of in_bp, descending addresses
        S_IN_CHK: begin
          if (in_cur != '0 && in_bp < in_cur && n < WALK_MAX) begin
            in_pv <= in_cur;
            state <= S_IN_NX;
          end else begin
            state <= S_IN_W1;
          end
        end
        S_IN_NX: begin
          in_cur <= rdv;
          n      <= n + 1'b1;
          state  <= S_IN_CHK;
        end
        S_IN_W1: state <= S_IN_W2;
        S_IN_W2: state <= S_IN_W3;
        S_IN_W3: begin
          if (in_pv == '0) free_head <= in_bp;
          state <= S_IN_W4;
        end
        S_IN_W4: state <= ins_ret;

        // Coalesce mbp with free neighbors
        S_MG_START: state <= S_MG_SZ;
        S_MG_SZ: begin
          msize <= rsz;
          state <= S_MG_NU;
        end
        S_MG_NU: begin
          mg_nu <= rdv[0];
          state <= S_MG_PU;
        end
        S_MG_PU: begin
          pb <= mbp - rsz;
          nb <= mbp + msize;
          if (rdv[0] && mg_nu) begin
            in_bp   <= mbp;
            in_cur  <= free_head;
            in_pv   <= '0;
            n       <= '0;
            ins_ret <= S_MG_END;
            state   <= S_IN_CHK;
          end else if (rdv[0]) begin
            rm_bp  <= mbp + msize;
            rm_ret <= S_MG_B_RD;
            state  <= S_RM_R1;
          end else if (mg_nu) begin
            state <= S_MG_C_RD;
          end else begin
            rm_bp  <= mbp + msize;
            rm_ret <= S_MG_D_RD1;
            state  <= S_RM_R1;
          end
        end
        S_MG_B_RD: state <= S_MG_B_SZ;
        S_MG_B_SZ: begin
          msize   <= msize + rsz;
          st_bp   <= mbp;
          st_size <= msize + rsz;
          st_a    <= 1'b0;
          st_ret  <= S_MG_B_INS;
          state   <= S_ST_W1;
        end
        S_MG_B_INS: begin
          in_bp   <= mbp;
          in_cur  <= free_head;
          in_pv   <= '0;
          n       <= '0;
          ins_ret <= S_MG_END;
          state   <= S_IN_CHK;
        end
        S_MG_C_RD: state <= S_MG_C_SZ;
        S_MG_C_SZ: begin
          st_bp   <= pb;
          st_size <= msize + rsz;
          st_a    <= 1'b0;
          mbp     <= pb;
          st_ret  <= S_MG_END;
          state   <= S_ST_W1;
        end
        S_MG_D_RD1: state <= S_MG_D_RD2;
        S_MG_D_RD2: begin
          msize <= msize + rsz;
          state <= S_MG_D_SZ;
        end
        S_MG_D_SZ: begin
          st_bp   <= pb;
          st_size <= msize + rsz;
          st_a    <= 1'b0;
          mbp     <= pb;
          st_ret  <= S_MG_END;
          state   <= S_ST_W1;
        end
        S_MG_END: begin
          if (!mg_grow) begin
            state <= S_DONE;
          end else if (mbp == '0) begin
            stat  <= ST_NO_SPACE;
            state <= S_DONE;
          end else begin
            tbp   <= mbp;
            res   <= mbp;
            state <= S_TK_START;
          end
        end

        // Validate a free by walking block headers from the heap base
        S_FR_CHK: state <= (wk < top32 && n < WALK_MAX) ? S_FR_HD : S_DONE;
        S_FR_HD: begin
          if (wk == addr_q) begin
            if (rdv[0] && rsz != '0) begin
              st_bp   <= addr_q;
              st_size <= rsz;
              st_a    <= 1'b0;
              st_ret  <= S_FR_MG;
              state   <= S_ST_W1;
            end else begin
              state <= S_DONE;
            end
          end else if (rsz == '0 || wk > addr_q) begin
            state <= S_DONE;
          end else begin
            wk    <= wk + rsz;
            n     <= n + 1'b1;
            state <= S_FR_CHK;
          end
        end
        S_FR_MG: begin
          mbp     <= addr_q;
          mg_grow <= 1'b0;
          state   <= S_MG_START;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A failed or zero size request never hands out an address.
  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> result_addr == '0)
    else $error("nonzero address with failing status");

  // Only one request is in work at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // A limit write takes effect on the next cycle.
  a_limit_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index == CFG_LIMIT |=> limit == $past(cfg_data))
    else $error("heap limit write lost");

endmodule
